[rtl/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types, command codes and register indexes for the I2C master engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd1;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd250;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_STA1   = 5'd1,
        ST_STA2   = 5'd2,
        ST_STA3   = 5'd3,
        ST_STO1   = 5'd4,
        ST_STO2   = 5'd5,
        ST_FIN    = 5'd6,
        ST_WCLKH  = 5'd7,
        ST_WCLKL  = 5'd8,
        ST_WBIT   = 5'd9,
        ST_WREL   = 5'd10,
        ST_WCLKL2 = 5'd11,
        ST_AREL   = 5'd12,
        ST_ACLKH  = 5'd13,
        ST_APOLL  = 5'd14,
        ST_RCLKH  = 5'd15,
        ST_RCLKL  = 5'd16,
        ST_RACK   = 5'd17,
        ST_RACKH  = 5'd18,
        ST_RACKL  = 5'd19
    } i2cm_step_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] write_byte;
        logic       read_ack;
        logic       sda_sample;
    } i2cm_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_failed;
    } i2cm_result_t;

    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [15:0] ack_timeout;
    } i2cm_cfg_t;

endpackage

[rtl/i2cm_core.sv]
// ----------------------------------------------------------------------------
// I2C master sequencer
// Pin sequence state machine, bit counters, shifter and ACK polling; advances
// by one tick for each request that it is given.
// ----------------------------------------------------------------------------
module i2cm_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  i2cm_pkg::i2cm_item_t  item,
    input  i2cm_pkg::i2cm_cfg_t   cfg,
    output i2cm_pkg::i2cm_result_t result
);

    i2cm_pkg::i2cm_step_t state_reg, state_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] phase_count_reg, phase_count_next;
    logic [15:0] poll_count_reg, poll_count_next;
    logic        scl_out_reg, scl_out_next;
    logic        sda_out_reg, sda_out_next;
    logic        nack_flag_reg, nack_flag_next;
    logic        ack_after_read_reg, ack_after_read_next;
    logic [7:0]  read_latch_reg, read_latch_next;
    logic        done;

    logic [15:0] hold_value;
    logic [3:0]  bit_inc;
    logic        running;

    assign hold_value = ((cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks) - 16'd1;
    assign bit_inc    = bit_count_reg + 4'd1;
    assign running    = (state_reg != i2cm_pkg::ST_IDLE) && (phase_count_reg == 16'd0);

    always_comb
    begin
        state_next = state_reg;
        if (state_reg == i2cm_pkg::ST_IDLE) begin
            case (item.opcode)
                i2cm_pkg::OP_START: state_next = i2cm_pkg::ST_STA1;
                i2cm_pkg::OP_STOP:  state_next = i2cm_pkg::ST_STO1;
                i2cm_pkg::OP_WRITE: state_next = i2cm_pkg::ST_WCLKH;
                i2cm_pkg::OP_READ:  state_next = i2cm_pkg::ST_RCLKH;
                default:            state_next = i2cm_pkg::ST_IDLE;
            endcase
        end else if (running) begin
            case (state_reg)
                i2cm_pkg::ST_STA1:   state_next = i2cm_pkg::ST_STA2;
                i2cm_pkg::ST_STA2:   state_next = i2cm_pkg::ST_STA3;
                i2cm_pkg::ST_STA3:   state_next = i2cm_pkg::ST_FIN;
                i2cm_pkg::ST_STO1:   state_next = i2cm_pkg::ST_STO2;
                i2cm_pkg::ST_STO2:   state_next = i2cm_pkg::ST_FIN;
                i2cm_pkg::ST_FIN:    state_next = i2cm_pkg::ST_IDLE;
                i2cm_pkg::ST_WCLKH:  state_next = i2cm_pkg::ST_WCLKL;
                i2cm_pkg::ST_WCLKL:
                    state_next = bit_count_reg[3] ? i2cm_pkg::ST_WREL : i2cm_pkg::ST_WBIT;
                i2cm_pkg::ST_WBIT:   state_next = i2cm_pkg::ST_WCLKH;
                i2cm_pkg::ST_WREL:   state_next = i2cm_pkg::ST_WCLKL2;
                i2cm_pkg::ST_WCLKL2: state_next = i2cm_pkg::ST_AREL;
                i2cm_pkg::ST_AREL:   state_next = i2cm_pkg::ST_ACLKH;
                i2cm_pkg::ST_ACLKH:  state_next = i2cm_pkg::ST_APOLL;
                i2cm_pkg::ST_APOLL:
                    if (!item.sda_sample) begin
                        state_next = i2cm_pkg::ST_IDLE;
                    end else if (poll_count_reg >= cfg.ack_timeout) begin
                        state_next = i2cm_pkg::ST_STO1;
                    end
                i2cm_pkg::ST_RCLKH:
                    state_next = bit_inc[3] ? i2cm_pkg::ST_RACK : i2cm_pkg::ST_RCLKL;
                i2cm_pkg::ST_RCLKL:  state_next = i2cm_pkg::ST_RCLKH;
                i2cm_pkg::ST_RACK:   state_next = i2cm_pkg::ST_RACKH;
                i2cm_pkg::ST_RACKH:  state_next = i2cm_pkg::ST_RACKL;
                i2cm_pkg::ST_RACKL:  state_next = i2cm_pkg::ST_FIN;
                default:             state_next = i2cm_pkg::ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        bit_count_next      = bit_count_reg;
        shift_next          = shift_reg;
        phase_count_next    = hold_value;
        poll_count_next     = poll_count_reg;
        scl_out_next        = scl_out_reg;
        sda_out_next        = sda_out_reg;
        nack_flag_next      = nack_flag_reg;
        ack_after_read_next = ack_after_read_reg;
        read_latch_next     = read_latch_reg;
        done                = 1'b0;
        if (state_reg == i2cm_pkg::ST_IDLE) begin
            case (item.opcode)
                i2cm_pkg::OP_START: sda_out_next = 1'b1;
                i2cm_pkg::OP_STOP:  sda_out_next = 1'b0;
                i2cm_pkg::OP_WRITE:
                begin
                    nack_flag_next = 1'b0;
                    scl_out_next   = 1'b0;
                    sda_out_next   = item.write_byte[7];
                    shift_next     = {item.write_byte[6:0], 1'b0};
                    bit_count_next = 4'd1;
                end
                i2cm_pkg::OP_READ:
                begin
                    ack_after_read_next = item.read_ack;
                    sda_out_next        = 1'b1;
                    scl_out_next        = 1'b0;
                    bit_count_next      = 4'd0;
                end
                default: phase_count_next = phase_count_reg;
            endcase
        end else if (!running) begin
            phase_count_next = phase_count_reg - 16'd1;
        end else begin
            case (state_reg)
                i2cm_pkg::ST_STA1:   scl_out_next = 1'b1;
                i2cm_pkg::ST_STA2:   sda_out_next = 1'b0;
                i2cm_pkg::ST_STA3:   scl_out_next = 1'b0;
                i2cm_pkg::ST_STO1:   scl_out_next = 1'b1;
                i2cm_pkg::ST_STO2:   sda_out_next = 1'b1;
                i2cm_pkg::ST_FIN:
                begin
                    done             = 1'b1;
                    phase_count_next = phase_count_reg;
                end
                i2cm_pkg::ST_WCLKH:  scl_out_next = 1'b1;
                i2cm_pkg::ST_WCLKL:  scl_out_next = 1'b0;
                i2cm_pkg::ST_WBIT:
                begin
                    sda_out_next   = shift_reg[7];
                    shift_next     = {shift_reg[6:0], 1'b0};
                    bit_count_next = bit_inc;
                end
                i2cm_pkg::ST_WREL:   sda_out_next = 1'b1;
                i2cm_pkg::ST_WCLKL2: scl_out_next = 1'b0;
                i2cm_pkg::ST_AREL:   sda_out_next = 1'b1;
                i2cm_pkg::ST_ACLKH:
                begin
                    scl_out_next    = 1'b1;
                    poll_count_next = 16'd0;
                end
                i2cm_pkg::ST_APOLL:
                    if (!item.sda_sample) begin
                        scl_out_next     = 1'b0;
                        done             = 1'b1;
                        phase_count_next = phase_count_reg;
                    end else if (poll_count_reg >= cfg.ack_timeout) begin
                        nack_flag_next = 1'b1;
                        sda_out_next   = 1'b0;
                    end else begin
                        poll_count_next  = poll_count_reg + 16'd1;
                        phase_count_next = phase_count_reg;
                    end
                i2cm_pkg::ST_RCLKH:
                begin
                    scl_out_next   = 1'b1;
                    shift_next     = {shift_reg[6:0], item.sda_sample};
                    bit_count_next = bit_inc;
                end
                i2cm_pkg::ST_RCLKL:  scl_out_next = 1'b0;
                i2cm_pkg::ST_RACK:
                begin
                    scl_out_next    = 1'b0;
                    sda_out_next    = !ack_after_read_reg;
                    read_latch_next = shift_reg;
                end
                i2cm_pkg::ST_RACKH:  scl_out_next = 1'b1;
                i2cm_pkg::ST_RACKL:  scl_out_next = 1'b0;
                default:             phase_count_next = phase_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg          <= i2cm_pkg::ST_IDLE;
            bit_count_reg      <= 4'd0;
            shift_reg          <= 8'd0;
            phase_count_reg    <= 16'd0;
            poll_count_reg     <= 16'd0;
            scl_out_reg        <= 1'b1;
            sda_out_reg        <= 1'b1;
            nack_flag_reg      <= 1'b0;
            ack_after_read_reg <= 1'b0;
            read_latch_reg     <= 8'd0;
        end else if (step) begin
            state_reg          <= state_next;
            bit_count_reg      <= bit_count_next;
            shift_reg          <= shift_next;
            phase_count_reg    <= phase_count_next;
            poll_count_reg     <= poll_count_next;
            scl_out_reg        <= scl_out_next;
            sda_out_reg        <= sda_out_next;
            nack_flag_reg      <= nack_flag_next;
            ack_after_read_reg <= ack_after_read_next;
            read_latch_reg     <= read_latch_next;
        end
    end

    always_comb
    begin
        result.scl_level    = scl_out_next;
        result.sda_pull_low = !sda_out_next;
        result.busy_res     = (state_next != i2cm_pkg::ST_IDLE);
        result.done_res     = done;
        result.read_data    = read_latch_next;
        result.ack_failed   = nack_flag_next;
    end

    // The pins never move while a hold is still counting down.
    a_hold_pins: assert property (@(posedge clk) disable iff (!rst_n)
        step && state_reg != i2cm_pkg::ST_IDLE && phase_count_reg != 16'd0
        |=> $stable(scl_out_reg) && $stable(sda_out_reg) && $stable(state_reg))
        else $error("pin levels changed during a hold");

    // A failed acknowledge is only ever flagged out of the polling step.
    a_nack_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(nack_flag_reg) |-> $past(state_reg) == i2cm_pkg::ST_APOLL)
        else $error("acknowledge failure flagged outside polling");

    // Completion leaves the engine idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> state_reg == i2cm_pkg::ST_IDLE)
        else $error("engine still busy after completion");

endmodule

[rtl/i2c_master_byte_engine.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine
// Bit-level I2C master: each request is one tick carrying the sampled SDA
// level and, while idle, a start, stop, write or read command.
//
//   channel  direction  handshake                    payload
//   item     in         item_valid / item_ready      i2cm_item_t
//   result   out        result_valid / result_ready  i2cm_result_t
//   cfg      in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One request is taken in every cycle while no result is stalled; its result
// is registered and appears on the cycle after acceptance. The result side
// sets the rate: a stalled result holds its register and blocks new requests
// only while it waits. Reset releases the pins and restores cfg defaults.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  i2cm_pkg::i2cm_item_t   item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output i2cm_pkg::i2cm_result_t result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_data
);

    i2cm_pkg::i2cm_cfg_t    cfg_reg;
    i2cm_pkg::i2cm_result_t result_next;
    i2cm_pkg::i2cm_result_t result_reg;
    logic                   result_valid_reg;
    logic                   accept;

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.phase_ticks <= i2cm_pkg::PHASE_TICKS_RESET;
            cfg_reg.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                i2cm_pkg::CFG_PHASE_TICKS: cfg_reg.phase_ticks <= cfg_data;
                i2cm_pkg::CFG_ACK_TIMEOUT: cfg_reg.ack_timeout <= cfg_data;
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    i2cm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else if (item_ready) begin
            result_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[verif/i2c_master_byte_engine_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Feeds the engine a stream of tick requests: directed start, stop, write and
// read commands first, then random transactions under several register
// settings. A cycle-accurate shadow of the pin sequencer forecasts the pins
// for every accepted request, and each returned result is checked against
// the oldest forecast. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_test;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {SDA_FREE, SDA_ACKING, SDA_LATE, SDA_SILENT} sda_drive_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    i2cm_pkg::i2cm_item_t   item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    i2cm_pkg::i2cm_result_t result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = i2cm_pkg::CFG_PHASE_TICKS;
    logic [15:0]            cfg_data = '0;

    i2cm_pkg::i2cm_item_t   tick_queue[$];
    i2cm_pkg::i2cm_result_t expected_pins[$];
    i2cm_pkg::i2cm_result_t want_pins;
    int                     ticks_queued = 0;
    int                     ticks_accepted = 0;
    int                     error_count = 0;
    int                     cycle_count = 0;

    logic [15:0]            sh_phase_ticks = i2cm_pkg::PHASE_TICKS_RESET;
    logic [15:0]            sh_ack_timeout = i2cm_pkg::ACK_TIMEOUT_RESET;
    i2cm_pkg::i2cm_step_t   sh_step = i2cm_pkg::ST_IDLE;
    logic [3:0]             sh_bits = '0;
    logic [7:0]             sh_shift = '0;
    logic [15:0]            sh_hold = '0;
    logic [15:0]            sh_polls = '0;
    logic                   sh_scl = 1'b1;
    logic                   sh_sda = 1'b1;
    logic                   sh_nack = 1'b0;
    logic                   sh_read_ack = 1'b0;
    logic [7:0]             sh_read_latch = '0;

    int                     tx_gap = 0;
    int                     tx_calm_left = 0;
    logic                   tx_calm = 1'b0;
    int                     rx_gap = 0;
    int                     rx_hold = 0;
    int                     rx_accepts = 0;
    int                     rx_calm_left = 0;
    logic                   rx_calm = 1'b0;

    i2c_master_byte_engine u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void hold_then(input i2cm_pkg::i2cm_step_t nxt);
        sh_hold = (sh_phase_ticks == 16'd0) ? 16'd0 : sh_phase_ticks - 16'd1;
        sh_step = nxt;
    endfunction

    function automatic void shift_out_bit();
        sh_sda = sh_shift[7];
        sh_shift = {sh_shift[6:0], 1'b0};
        sh_bits = sh_bits + 4'd1;
    endfunction

    function automatic i2cm_pkg::i2cm_result_t predict_pins(input i2cm_pkg::i2cm_item_t req);
        i2cm_pkg::i2cm_result_t pins;
        logic                   done;
        done = 1'b0;
        if (sh_step == i2cm_pkg::ST_IDLE)
        begin
            case (req.opcode)
                i2cm_pkg::OP_START:
                begin
                    sh_sda = 1'b1;
                    hold_then(i2cm_pkg::ST_STA1);
                end
                i2cm_pkg::OP_STOP:
                begin
                    sh_sda = 1'b0;
                    hold_then(i2cm_pkg::ST_STO1);
                end
                i2cm_pkg::OP_WRITE:
                begin
                    sh_nack = 1'b0;
                    sh_scl = 1'b0;
                    sh_shift = req.write_byte;
                    sh_bits = 4'd0;
                    shift_out_bit();
                    hold_then(i2cm_pkg::ST_WCLKH);
                end
                i2cm_pkg::OP_READ:
                begin
                    sh_read_ack = req.read_ack;
                    sh_sda = 1'b1;
                    sh_scl = 1'b0;
                    sh_bits = 4'd0;
                    hold_then(i2cm_pkg::ST_RCLKH);
                end
                default: ;
            endcase
        end
        else if (sh_hold != 16'd0)
            sh_hold = sh_hold - 16'd1;
        else
        begin
            case (sh_step)
                i2cm_pkg::ST_STA1:
                begin
                    sh_scl = 1'b1;
                    hold_then(i2cm_pkg::ST_STA2);
                end
                i2cm_pkg::ST_STA2:
                begin
                    sh_sda = 1'b0;
                    hold_then(i2cm_pkg::ST_STA3);
                end
                i2cm_pkg::ST_STA3:
                begin
                    sh_scl = 1'b0;
                    hold_then(i2cm_pkg::ST_FIN);
                end
                i2cm_pkg::ST_STO1:
                begin
                    sh_scl = 1'b1;
                    hold_then(i2cm_pkg::ST_STO2);
                end
                i2cm_pkg::ST_STO2:
                begin
                    sh_sda = 1'b1;
                    hold_then(i2cm_pkg::ST_FIN);
                end
                i2cm_pkg::ST_FIN:
                begin
                    sh_step = i2cm_pkg::ST_IDLE;
                    done = 1'b1;
                end
                i2cm_pkg::ST_WCLKH:
                begin
                    sh_scl = 1'b1;
                    hold_then(i2cm_pkg::ST_WCLKL);
                end
                i2cm_pkg::ST_WCLKL:
                begin
                    sh_scl = 1'b0;
                    if (sh_bits >= 4'd8)
                        hold_then(i2cm_pkg::ST_WREL);
                    else
                        hold_then(i2cm_pkg::ST_WBIT);
                end
                i2cm_pkg::ST_WBIT:
                begin
                    shift_out_bit();
                    hold_then(i2cm_pkg::ST_WCLKH);
                end
                i2cm_pkg::ST_WREL:
                begin
                    sh_sda = 1'b1;
                    hold_then(i2cm_pkg::ST_WCLKL2);
                end
                i2cm_pkg::ST_WCLKL2:
                begin
                    sh_scl = 1'b0;
                    hold_then(i2cm_pkg::ST_AREL);
                end
                i2cm_pkg::ST_AREL:
                begin
                    sh_sda = 1'b1;
                    hold_then(i2cm_pkg::ST_ACLKH);
                end
                i2cm_pkg::ST_ACLKH:
                begin
                    sh_scl = 1'b1;
                    sh_polls = 16'd0;
                    hold_then(i2cm_pkg::ST_APOLL);
                end
                i2cm_pkg::ST_APOLL:
                begin
                    if (!req.sda_sample)
                    begin
                        sh_scl = 1'b0;
                        sh_step = i2cm_pkg::ST_IDLE;
                        done = 1'b1;
                    end
                    else if (sh_polls >= sh_ack_timeout)
                    begin
                        sh_nack = 1'b1;
                        sh_sda = 1'b0;
                        hold_then(i2cm_pkg::ST_STO1);
                    end
                    else
                        sh_polls = sh_polls + 16'd1;
                end
                i2cm_pkg::ST_RCLKH:
                begin
                    sh_scl = 1'b1;
                    sh_shift = {sh_shift[6:0], req.sda_sample};
                    sh_bits = sh_bits + 4'd1;
                    if (sh_bits >= 4'd8)
                        hold_then(i2cm_pkg::ST_RACK);
                    else
                        hold_then(i2cm_pkg::ST_RCLKL);
                end
                i2cm_pkg::ST_RCLKL:
                begin
                    sh_scl = 1'b0;
                    hold_then(i2cm_pkg::ST_RCLKH);
                end
                i2cm_pkg::ST_RACK:
                begin
                    sh_scl = 1'b0;
                    sh_sda = ~sh_read_ack;
                    sh_read_latch = sh_shift;
                    hold_then(i2cm_pkg::ST_RACKH);
                end
                i2cm_pkg::ST_RACKH:
                begin
                    sh_scl = 1'b1;
                    hold_then(i2cm_pkg::ST_RACKL);
                end
                i2cm_pkg::ST_RACKL:
                begin
                    sh_scl = 1'b0;
                    hold_then(i2cm_pkg::ST_FIN);
                end
                default: sh_step = i2cm_pkg::ST_IDLE;
            endcase
        end
        pins.scl_level    = sh_scl;
        pins.sda_pull_low = ~sh_sda;
        pins.busy_res     = (sh_step != i2cm_pkg::ST_IDLE);
        pins.done_res     = done;
        pins.read_data    = sh_read_latch;
        pins.ack_failed   = sh_nack;
        return pins;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic sda_level(input sda_drive_t mode);
        case (mode)
            SDA_ACKING: return ($urandom_range(0, 3) == 0);
            SDA_LATE:   return ($urandom_range(0, 15) != 0);
            SDA_SILENT: return 1'b1;
            default:    return ($urandom_range(0, 1) == 1);
        endcase
    endfunction

    function automatic void push_tick(input logic [2:0] op, input logic [7:0] wb,
                                      input logic rack, input logic sda);
        i2cm_pkg::i2cm_item_t req;
        req.opcode     = op;
        req.write_byte = wb;
        req.read_ack   = rack;
        req.sda_sample = sda;
        tick_queue.push_back(req);
        ticks_queued++;
    endfunction

    // A command followed by idle ticks; noisy fillers carry the odd stray opcode.
    function automatic void queue_command(input logic [2:0] op, input logic [7:0] wb,
                                          input logic rack, input sda_drive_t mode,
                                          input int fill, input logic noisy);
        int         k;
        logic [2:0] filler_op;
        push_tick(op, wb, rack, sda_level(mode));
        for (k = 0; k < fill; k++)
        begin
            filler_op = i2cm_pkg::OP_NONE;
            if (noisy && $urandom_range(0, 15) == 0)
                filler_op = 3'($urandom_range(0, 7));
            push_tick(filler_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      sda_level(mode));
        end
    endfunction

    function automatic void random_phase(input int p, input int t, input int budget);
        int         first;
        int         pick;
        int         scale;
        int         fill;
        sda_drive_t mode;
        logic [2:0] op;
        first = ticks_queued;
        scale = (p == 0) ? 1 : p;
        while (ticks_queued - first < budget)
        begin
            pick = $urandom_range(0, 99);
            mode = SDA_FREE;
            if (pick < 15)
            begin
                op = i2cm_pkg::OP_START;
                fill = 5 * scale;
            end
            else if (pick < 30)
            begin
                op = i2cm_pkg::OP_STOP;
                fill = 4 * scale;
            end
            else if (pick < 65)
            begin
                op = i2cm_pkg::OP_WRITE;
                fill = 30 * scale;
                pick = $urandom_range(0, 9);
                mode = (pick < 6) ? SDA_ACKING : (pick < 8) ? SDA_LATE : SDA_SILENT;
                if (mode != SDA_ACKING)
                    fill = fill + ((t < 300) ? t : 300);
            end
            else if (pick < 90)
            begin
                op = i2cm_pkg::OP_READ;
                fill = 28 * scale;
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    op = i2cm_pkg::OP_NONE;
                else
                    op = i2cm_pkg::OP_READ + 3'($urandom_range(1, 3));
                fill = 3;
            end
            fill = $urandom_range(fill / 2, fill + 8);
            if (fill > 400)
                fill = 400;
            queue_command(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), mode,
                          fill, 1'b1);
        end
    endfunction

    task automatic drain();
        do
            @(posedge clk);
        while (ticks_accepted != ticks_queued || expected_pins.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        drain();
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == i2cm_pkg::CFG_PHASE_TICKS)
                sh_phase_ticks = cfg_data;
            else
                sh_ack_timeout = cfg_data;
        end
        if (rst_n && item_valid && item_ready)
        begin
            expected_pins.push_back(predict_pins(item));
            ticks_accepted = ticks_accepted + 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            tx_gap     <= 0;
        end
        else
        begin
            if (tx_calm_left == 0)
            begin
                tx_calm_left <= $urandom_range(50, 250);
                tx_calm      <= ~tx_calm;
            end
            else
                tx_calm_left <= tx_calm_left - 1;
            if (!item_valid || item_ready)
            begin
                if (tx_gap != 0)
                begin
                    item_valid <= 1'b0;
                    tx_gap     <= tx_gap - 1;
                end
                else if (tick_queue.size() != 0)
                begin
                    item       <= tick_queue.pop_front();
                    item_valid <= 1'b1;
                    tx_gap     <= tx_calm ? 0 : pick_gap();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Two long receive stalls let the engine back up and hold off new requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            rx_gap       <= 0;
            rx_hold      <= 0;
        end
        else
        begin
            if (rx_calm_left == 0)
            begin
                rx_calm_left <= $urandom_range(50, 250);
                rx_calm      <= ~rx_calm;
            end
            else
                rx_calm_left <= rx_calm_left - 1;
            if (result_valid && result_ready)
                rx_accepts <= rx_accepts + 1;
            if (rx_hold != 0)
            begin
                result_ready <= 1'b0;
                rx_hold      <= rx_hold - 1;
            end
            else if (result_valid && result_ready && (rx_accepts == 300 || rx_accepts == 1500))
            begin
                result_ready <= 1'b0;
                rx_hold      <= 600;
            end
            else if (rx_gap != 0)
            begin
                result_ready <= 1'b0;
                rx_gap       <= rx_gap - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                if (result_valid && result_ready)
                    rx_gap <= rx_calm ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_pins.size() == 0)
            begin
                if (error_count < REPORT_LIMIT)
                    $display("unexpected result at cycle %0d", cycle_count);
                error_count = error_count + 1;
            end
            else
            begin
                want_pins = expected_pins.pop_front();
                if (result !== want_pins)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display({"pin mismatch at cycle %0d (got/expected): scl %b/%b ",
                                  "sda_low %b/%b busy %b/%b done %b/%b data %h/%h nack %b/%b"},
                                 cycle_count, result.scl_level, want_pins.scl_level,
                                 result.sda_pull_low, want_pins.sda_pull_low,
                                 result.busy_res, want_pins.busy_res,
                                 result.done_res, want_pins.done_res,
                                 result.read_data, want_pins.read_data,
                                 result.ack_failed, want_pins.ack_failed);
                    error_count = error_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("i2c_master_byte_engine verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings, including a full timeout of 250 polls.
        queue_command(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_FREE, 6, 1'b0);
        queue_command(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_ACKING, 35, 1'b0);
        queue_command(i2cm_pkg::OP_WRITE, 8'h00, 1'b1, SDA_ACKING, 35, 1'b0);
        queue_command(i2cm_pkg::OP_WRITE, 8'hA5, 1'b0, SDA_SILENT, 300, 1'b0);
        queue_command(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_FREE, 6, 1'b0);
        queue_command(i2cm_pkg::OP_WRITE, 8'h5A, 1'b1, SDA_LATE, 60, 1'b0);
        queue_command(i2cm_pkg::OP_START, 8'hFF, 1'b1, SDA_FREE, 6, 1'b0);
        queue_command(i2cm_pkg::OP_READ, 8'h00, 1'b1, SDA_FREE, 30, 1'b0);
        queue_command(i2cm_pkg::OP_READ, 8'hFF, 1'b0, SDA_SILENT, 30, 1'b0);
        queue_command(i2cm_pkg::OP_READ, 8'h3C, 1'b1, SDA_ACKING, 30, 1'b0);
        queue_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_FREE, 6, 1'b0);
        queue_command(i2cm_pkg::OP_READ + 3'd1, 8'hFF, 1'b1, SDA_FREE, 1, 1'b0);
        queue_command(i2cm_pkg::OP_READ + 3'd2, 8'hFF, 1'b1, SDA_FREE, 1, 1'b0);
        queue_command(i2cm_pkg::OP_READ + 3'd3, 8'hFF, 1'b1, SDA_FREE, 1, 1'b0);
        queue_command(i2cm_pkg::OP_NONE, 8'h00, 1'b0, SDA_FREE, 2, 1'b0);
        queue_command(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_FREE, 0, 1'b0);
        queue_command(i2cm_pkg::OP_WRITE, 8'h81, 1'b1, SDA_ACKING, 40, 1'b0);
        queue_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_FREE, 6, 1'b0);

        write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd0);
        random_phase(1, 0, 120);
        write_reg(i2cm_pkg::CFG_PHASE_TICKS, 16'd0);
        write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd1);
        random_phase(0, 1, 120);
        write_reg(i2cm_pkg::CFG_PHASE_TICKS, 16'd2);
        write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd5);
        random_phase(2, 5, 150);
        write_reg(i2cm_pkg::CFG_PHASE_TICKS, 16'd1);
        write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd65535);
        random_phase(1, 65535, 120);
        write_reg(i2cm_pkg::CFG_PHASE_TICKS, 16'd3);
        write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd20);
        random_phase(3, 20, 150);
        write_reg(i2cm_pkg::CFG_PHASE_TICKS, i2cm_pkg::PHASE_TICKS_RESET);
        write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, i2cm_pkg::ACK_TIMEOUT_RESET);
        random_phase(1, 250, 150);
        // The longest hold goes last: nothing after it would get past the count.
        write_reg(i2cm_pkg::CFG_PHASE_TICKS, 16'd65535);
        write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd3);
        random_phase(65535, 3, 150);

        drain();
        repeat (10)
            @(posedge clk);
        if (error_count == 0)
            $display("i2c_master_byte_engine verification clean");
        else
            $display("i2c_master_byte_engine verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/i2cm_pkg.sv
rtl/i2cm_core.sv
rtl/i2c_master_byte_engine.sv
verif/i2c_master_byte_engine_test.sv
